// File: rtl/fnv1a64_crlf_normalized_hash_assert.svh
// ----------------------------------------------------------------------------
// fnv1a64_crlf_normalized_hash assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef FNV1A64_CRLF_NORMALIZED_HASH_ASSERT_SVH
`define FNV1A64_CRLF_NORMALIZED_HASH_ASSERT_SVH

// same-cycle implication
`define FNVCR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fnvcr assertion failed");

// next-cycle implication
`define FNVCR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fnvcr assertion failed");

`endif

// File: rtl/fnvcr_pkg.sv
// ----------------------------------------------------------------------------
// fnvcr_pkg
// shared types, constants and the fnv-1a mix function
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fnvcr_pkg;

    localparam logic [63:0] FNV_OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [7:0]  CHAR_CR          = 8'h0D;
    localparam logic [7:0]  CHAR_LF          = 8'h0A;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_MIX_CR,
        DP_BYTE,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctl_cmd_t;

    typedef struct packed {
        logic held;
        logic present;
        logic last;
        logic is_lf;
        logic out_free;
    } dp_sts_t;

    // prime 0x100000001B3 = 2^40 + 2^8 + 0xB3, 0xB3 = 128 + 32 + 16 + 2 + 1
    function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// File: rtl/fnvcr_datapath.sv
// ----------------------------------------------------------------------------
// fnvcr_datapath
// item latch, running hash, held cr flag and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnvcr_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  fnvcr_pkg::ctl_cmd_t cmd,
    output fnvcr_pkg::dp_sts_t  sts,
    input  logic [7:0]         s_data_byte,
    input  logic               s_byte_present,
    input  logic               s_end_of_stream,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [63:0]        m_fingerprint
);
    import fnvcr_pkg::*;

    logic [7:0]  byte_reg;
    logic        present_reg;
    logic        last_reg;
    logic [63:0] hash_reg,  hash_next;
    logic        held_reg,  held_next;
    logic        mvalid_reg, mvalid_next;
    logic [63:0] fp_reg;
    logic [7:0]  mix_byte;
    logic [63:0] mix_out;
    logic        out_free;

    assign out_free = !mvalid_reg || m_ready;

    // single shared mixer
    always_comb begin
        mix_byte = byte_reg;
        if (cmd.op == DP_MIX_CR || cmd.op == DP_EMIT) begin
            mix_byte = CHAR_CR;
        end
        mix_out = fnv_mix(hash_reg, mix_byte);
    end

    always_comb begin
        hash_next   = hash_reg;
        held_next   = held_reg;
        mvalid_next = mvalid_reg && !m_ready;
        case (cmd.op)
            DP_MIX_CR: begin
                hash_next = mix_out;
                held_next = 1'b0;
            end
            DP_BYTE: begin
                if (byte_reg == CHAR_CR) begin
                    held_next = 1'b1;
                end else begin
                    hash_next = mix_out;
                    held_next = 1'b0;
                end
            end
            DP_EMIT: begin
                hash_next   = FNV_OFFSET_BASIS;
                held_next   = 1'b0;
                mvalid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg   <= FNV_OFFSET_BASIS;
            held_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            hash_reg   <= hash_next;
            held_reg   <= held_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.op == DP_LOAD) begin
            byte_reg    <= s_data_byte;
            present_reg <= s_byte_present;
            last_reg    <= s_end_of_stream;
        end
        if (cmd.op == DP_EMIT) begin
            fp_reg <= held_reg ? mix_out : hash_reg;
        end
    end

    assign sts.held     = held_reg;
    assign sts.present  = present_reg;
    assign sts.last     = last_reg;
    assign sts.is_lf    = (byte_reg == CHAR_LF);
    assign sts.out_free = out_free;

    assign m_valid       = mvalid_reg;
    assign m_fingerprint = fp_reg;

endmodule

// File: rtl/fnvcr_ctrl.sv
// ----------------------------------------------------------------------------
// fnvcr_ctrl
// sequencer issuing one datapath operation per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnvcr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fnvcr_pkg::dp_sts_t  sts,
    output fnvcr_pkg::ctl_cmd_t cmd
);
    import fnvcr_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (sts.present && sts.held && !sts.is_lf) begin
                    state_next = ST_STEP;
                end else if (sts.present) begin
                    state_next = sts.last ? ST_EMIT : ST_IDLE;
                end else if (sts.last && !sts.out_free) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = 1'b0;
        cmd.op  = DP_NOP;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = DP_LOAD;
                end
            end
            ST_STEP: begin
                if (sts.present && sts.held && !sts.is_lf) begin
                    cmd.op = DP_MIX_CR;
                end else if (sts.present) begin
                    cmd.op = DP_BYTE;
                end else if (sts.last && sts.out_free) begin
                    cmd.op = DP_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.op = DP_EMIT;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/fnv1a64_crlf_normalized_hash.sv
// ----------------------------------------------------------------------------
// fnv1a64_crlf_normalized_hash
// 64-bit fnv-1a over a byte stream with cr lf folded to lf
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | beat contents
//  --------+-----------+--------------------+-----------------------------------------
//  s_      | in        | s_valid / s_ready  | data_byte, byte_present, end_of_stream
//  m_      | out       | m_valid / m_ready  | fingerprint
//
//  an item is first accepted, then handled in one step of the sequencer
//  a byte after a held cr that is not lf first takes an extra step for the cr mix
//  an end beat carrying a byte then passes through ST_EMIT to load the output register
//  one mixer (xor and constant multiply) serves every mix, one per cycle
//  reset (aresetn low, synchronous) loads the offset basis and drops any held cr
//  a waiting result stalls only the next end beat, until the result is taken
//
`timescale 1ns / 1ps

module fnv1a64_crlf_normalized_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_end_of_stream,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_fingerprint
);
    import fnvcr_pkg::*;

    `include "fnv1a64_crlf_normalized_hash_assert.svh"

    // command and status between sequencer and datapath
    ctl_cmd_t ctl_cmd;
    dp_sts_t  dp_sts;

    fnvcr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (dp_sts),
        .cmd     (ctl_cmd)
    );

    // latch, running hash, held cr and output register
    fnvcr_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (ctl_cmd),
        .sts             (dp_sts),
        .s_data_byte     (s_data_byte),
        .s_byte_present  (s_byte_present),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_fingerprint   (m_fingerprint)
    );

    // a result is only loaded when the output register is free
    `FNVCR_ASSERT_NOW(a_emit_free, aclk, aresetn, ctl_cmd.op == DP_EMIT,
                      !m_valid || m_ready)

    // emitting returns the cr flag to clear
    `FNVCR_ASSERT_NEXT(a_emit_clears_cr, aclk, aresetn, ctl_cmd.op == DP_EMIT,
                       !dp_sts.held && m_valid)

    // a bare end beat accepted with a free output is loaded, emitted from ST_STEP, then shown on m_valid
    `FNVCR_ASSERT_NOW(a_bare_end_latency, aclk, aresetn,
                      s_valid && s_ready && s_end_of_stream && !s_byte_present && !m_valid,
                      ##2 m_valid)

endmodule
